>>> hw/rtl/fat_stamp_timezone_adjust_core_assert.svh
// Assertion macros shared by the timestamp time-zone adjust RTL.
`ifndef FAT_STAMP_TIMEZONE_ADJUST_CORE_ASSERT_SVH
`define FAT_STAMP_TIMEZONE_ADJUST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FSTA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsta: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FSTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsta: next-cycle check failed");

`endif

>>> hw/rtl/fsta_pkg.sv
// Types, constants and calendar helpers for the FAT timestamp time-zone adjust.
`default_nettype none

package fsta_pkg;

  typedef logic [15:0] fat_word_t;
  typedef logic [4:0]  hour_t;
  typedef logic [7:0]  zone_off_t;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_DEC_LAST = 5'd31;
  localparam logic [6:0]  YEAR_FIRST = 7'd0;
  localparam logic [6:0]  YEAR_2100 = 7'd120;
  localparam logic [6:0]  YEAR_LAST = 7'd127;
  localparam logic [15:0] TIME_LOW_MASK = 16'h07ff;
  localparam logic signed [6:0] HOURS_PER_DAY = 7'sd24;
  localparam logic signed [7:0] ZONE_OFF_MIN = -8'sd12;
  localparam logic signed [7:0] ZONE_OFF_MAX = 8'sd14;

  // Month lengths; month 0 and 13..15 count as 31 days
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // Days in a month, with the leap day in FAT years divisible by four but 2100
  function automatic logic [4:0] days_of(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] d;
    d = MONTH_LEN[month];
    if (month == MONTH_FEB && year[1:0] == 2'b00 && year != YEAR_2100) begin
      d = d + 5'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fsta_ifs.sv
// Valid/ready channel interfaces for the FAT timestamp time-zone adjust.
`default_nettype none

interface fsta_in_if
  import fsta_pkg::*;
;
  logic      valid;
  logic      ready;
  fat_word_t date_word;
  fat_word_t time_word;
  hour_t     utc_hour;

  modport source (output valid, date_word, time_word, utc_hour, input ready);
  modport sink   (input valid, date_word, time_word, utc_hour, output ready);
endinterface

interface fsta_out_if
  import fsta_pkg::*;
;
  logic      valid;
  logic      ready;
  fat_word_t local_date_word;
  fat_word_t local_time_word;
  hour_t     local_hour;
  logic      ok;

  modport source (output valid, local_date_word, local_time_word, local_hour, ok,
                  input ready);
  modport sink   (input valid, local_date_word, local_time_word, local_hour, ok,
                  output ready);
endinterface

interface fsta_cfg_if
  import fsta_pkg::*;
;
  logic      valid;
  logic      ready;
  zone_off_t zone_offset_hours;

  modport source (output valid, zone_offset_hours, input ready);
  modport sink   (input valid, zone_offset_hours, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fat_stamp_timezone_adjust_core.sv
// FAT timestamp time-zone adjust: top level with input and result registers.
//
// Usage:
//   in_if  carries a UTC FAT date word, FAT time word and hour; out_if returns
//   the local date word, time word with new hour bits, local hour and ok.
//   cfg_if writes the signed hour offset (always ready); write it only while
//   no transaction is in flight. Offsets outside -12..14 act as zero.
// Path: an accepted input transaction passes the input register, then the
//   calendar logic into the result register, before out_if.valid rises.
// Throughput: one transaction per cycle while out_if.ready is high; the two
//   register stages take a new input while a result waits on out_if.ready.
// Reset: synchronous active-low rst_n empties both stages and clears the
//   offset to zero.
// Stall: when out_if.ready is low the result holds; the input register still
//   fills once, after which in_if.ready drops until the result is taken.
// ok = 0 flags a step outside 1980-01-01..2107-12-31; the outputs then echo
//   the inputs unchanged.
`default_nettype none
`include "fat_stamp_timezone_adjust_core_assert.svh"

module fat_stamp_timezone_adjust_core
  import fsta_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  fsta_in_if.sink        in_if,
  fsta_out_if.source     out_if,
  fsta_cfg_if.sink       cfg_if
);

  // Offset register
  zone_off_t zone_off_r;

  // Input stage
  logic      s1_v_r;
  fat_word_t s1_date_r;
  fat_word_t s1_time_r;
  hour_t     s1_hour_r;

  // Result stage
  logic      out_v_r;
  fat_word_t out_date_r;
  fat_word_t out_time_r;
  hour_t     out_hour_r;
  logic      out_ok_r;

  logic      in_acc;
  logic      s1_adv;

  // Calendar datapath
  logic signed [7:0] off_raw;
  logic signed [5:0] off_eff;
  logic signed [6:0] hour_sum;
  logic signed [6:0] hour_adj;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [6:0] year_nxt;
  logic [3:0] month_nxt;
  logic [4:0] day_nxt;
  logic [4:0] cur_len;
  logic [4:0] prev_len;
  logic       ok_nxt;
  fat_word_t  date_nxt;
  fat_word_t  time_nxt;
  hour_t      hour_nxt;

  // Handshake
  assign s1_adv      = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // Hold the offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_off_r <= '0;
    end else if (cfg_if.valid) begin
      zone_off_r <= cfg_if.zone_offset_hours;
    end
  end

  // Advance the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_date_r <= in_if.date_word;
      s1_time_r <= in_if.time_word;
      s1_hour_r <= in_if.utc_hour;
    end
  end

  // Shift the hour and step the calendar one day on wrap
  always_comb begin
    off_raw  = signed'(zone_off_r);
    off_eff  = (off_raw < ZONE_OFF_MIN || off_raw > ZONE_OFF_MAX) ? 6'sd0 : off_raw[5:0];
    hour_sum = signed'({2'b00, s1_hour_r}) + {off_eff[5], off_eff};
    year     = s1_date_r[15:9];
    month    = s1_date_r[8:5];
    day      = s1_date_r[4:0];
    cur_len  = days_of(year, month);
    prev_len = days_of(year, month - 4'd1);
    year_nxt  = year;
    month_nxt = month;
    day_nxt   = day;
    ok_nxt    = 1'b1;
    hour_adj  = hour_sum;
    if (hour_sum < 7'sd0) begin
      hour_adj = hour_sum + HOURS_PER_DAY;
      priority if (day > DAY_FIRST) begin
        day_nxt = day - 5'd1;
      end else if (month > MONTH_JAN) begin
        month_nxt = month - 4'd1;
        day_nxt   = prev_len;
      end else if (year != YEAR_FIRST) begin
        year_nxt  = year - 7'd1;
        month_nxt = MONTH_DEC;
        day_nxt   = DAY_DEC_LAST;
      end else begin
        ok_nxt = 1'b0;
      end
    end else if (hour_sum >= HOURS_PER_DAY) begin
      hour_adj = hour_sum - HOURS_PER_DAY;
      priority if (day < cur_len) begin
        day_nxt = day + 5'd1;
      end else if (month < MONTH_DEC) begin
        month_nxt = month + 4'd1;
        day_nxt   = DAY_FIRST;
      end else if (year < YEAR_LAST) begin
        year_nxt  = year + 7'd1;
        month_nxt = MONTH_JAN;
        day_nxt   = DAY_FIRST;
      end else begin
        ok_nxt = 1'b0;
      end
    end
    if (ok_nxt) begin
      date_nxt = {year_nxt, month_nxt, day_nxt};
      time_nxt = (s1_time_r & TIME_LOW_MASK) | {hour_adj[4:0], 11'd0};
      hour_nxt = hour_adj[4:0];
    end else begin
      date_nxt = s1_date_r;
      time_nxt = s1_time_r;
      hour_nxt = s1_hour_r;
    end
  end

  // Advance the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_v_r && s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_date_r <= date_nxt;
      out_time_r <= time_nxt;
      out_hour_r <= hour_nxt;
      out_ok_r   <= ok_nxt;
    end
  end

  assign out_if.valid           = out_v_r;
  assign out_if.local_date_word = out_date_r;
  assign out_if.local_time_word = out_time_r;
  assign out_if.local_hour      = out_hour_r;
  assign out_if.ok              = out_ok_r;

  // Checks
  `FSTA_ASSERT_SAME(a_ok_hour_range, out_v_r && out_ok_r, out_hour_r < 5'd24)
  `FSTA_ASSERT_SAME(a_ok_hour_bits, out_v_r && out_ok_r, out_time_r[15:11] == out_hour_r)
  `FSTA_ASSERT_SAME(a_full_stall, s1_v_r && out_v_r && !out_if.ready, !in_if.ready)
  `FSTA_ASSERT_NEXT(a_fill_s1, in_acc, s1_v_r)

endmodule

`default_nettype wire
